// ===== src/sprfe_pkg.sv =====
// Shared types, codes and widths of the slab page remote-free engine.
// Depends on nothing; the interfaces, the top level and the divide unit use it.
`timescale 1ns / 1ps
`default_nettype none
package sprfe_pkg;

  // Fixed field widths.
  localparam int ADDR_W   = 64;
  localparam int SB_W     = 17;
  localparam int SIU_W    = 9;
  localparam int GEN_W    = 32;
  localparam int CNT_W    = 32;
  localparam int STAT_W   = 3;
  localparam int MODE_W   = 2;
  localparam int STRIPE_W = 2;
  localparam int SLOTF_W  = 8;
  localparam int TOTF_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 6;

  // Default geometry.
  localparam int DEF_SLOTS     = 256;
  localparam int DEF_STRIPES   = 4;
  localparam int DEF_MIN_ALIGN = 16;

  // Register reset values.
  localparam logic [SB_W-1:0]  SLOT_BYTES_RST   = SB_W'(64);
  localparam logic [SIU_W-1:0] SLOTS_IN_USE_RST = SIU_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE  = 2'd0,
    MODE_DRAIN = 2'd1,
    MODE_TAKE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_DRAINED   = 3'd3,
    ST_TAKEN     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_BASE  = 2'd0,
    REG_SLOT_BYTES = 2'd1,
    REG_SLOTS_USE  = 2'd2,
    REG_PAGE_GEN   = 2'd3
  } cfg_reg_t;

  // Request to the divide unit.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage
`default_nettype wire

// ===== src/sprfe_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on sprfe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface sprfe_in_if;
  logic                           valid;
  logic                           ready;
  logic [sprfe_pkg::MODE_W-1:0]   mode;
  logic [sprfe_pkg::ADDR_W-1:0]   address;
  logic [sprfe_pkg::GEN_W-1:0]    claimed_gen;
  logic                           any_generation;
  logic [sprfe_pkg::STRIPE_W-1:0] stripe;

  modport source (output valid, mode, address, claimed_gen, any_generation, stripe,
                  input ready);
  modport sink (input valid, mode, address, claimed_gen, any_generation, stripe,
                output ready);
endinterface

interface sprfe_out_if;
  logic                          valid;
  logic                          ready;
  logic [sprfe_pkg::STAT_W-1:0]  status;
  logic [sprfe_pkg::SLOTF_W-1:0] slot_id;
  logic [sprfe_pkg::TOTF_W-1:0]  merged_count;
  logic [sprfe_pkg::TOTF_W-1:0]  free_slots;
  logic [sprfe_pkg::CNT_W-1:0]   invalid_total;
  logic [sprfe_pkg::CNT_W-1:0]   duplicate_total;

  modport source (output valid, status, slot_id, merged_count, free_slots, invalid_total,
                  duplicate_total, input ready);
  modport sink (input valid, status, slot_id, merged_count, free_slots, invalid_total,
                duplicate_total, output ready);
endinterface
`default_nettype wire

// ===== src/slab_page_remote_free_engine_top.sv =====
// Top level of the slab page remote-free engine: sequencer, maps and counters.
// Depends on sprfe_pkg, sprfe_if, sprfe_div_unit and sprfe_link_ram.
//
//  Channel  Dir  Handshake     Carries
//  in_ch    in   valid/ready   mode, address, claimed_gen, any_generation, stripe
//  out_ch   out  valid/ready   status, slot_id, merged_count, free_slots, totals
//  cfg      in   cfg_we        cfg_index, cfg_data
//
// A remote free runs prepare, check, the slot division in the divide unit, the map
// update and finish; a failed range or generation check goes from check to finish.
// Alignment is a mask on the offset, tested with the division remainder.
// A drain selects and empties each stripe, popping its entries; a take pops the local top.
// One transaction is in work at a time; the finish step holds only while a result waits.
// Reset is synchronous and clears all control state; the link memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module slab_page_remote_free_engine_top #(
  parameter int SLOTS     = sprfe_pkg::DEF_SLOTS,
  parameter int STRIPES   = sprfe_pkg::DEF_STRIPES,
  parameter int MIN_ALIGN = sprfe_pkg::DEF_MIN_ALIGN
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [sprfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [sprfe_pkg::ADDR_W-1:0]    cfg_data,
  sprfe_in_if.sink                        in_ch,
  sprfe_out_if.source                     out_ch
);
  import sprfe_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LK_W  = $clog2(SLOTS + 1);
  localparam int ST_W  = (STRIPES > 1) ? $clog2(STRIPES) : 1;
  localparam int OFF_W = SB_W + IDX_W;
  localparam int DV_W  = OFF_W;
  localparam int SP_W  = SB_W + LK_W;
  localparam logic [LK_W-1:0] EMPTY = LK_W'(SLOTS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PREP  = 11'b00000000010,
    S_CHK   = 11'b00000000100,
    S_DIV1  = 11'b00000001000,
    S_MAP   = 11'b00000010000,
    S_DSEL  = 11'b00000100000,
    S_DCHK  = 11'b00001000000,
    S_DRD   = 11'b00010000000,
    S_TRD   = 11'b00100000000,
    S_TFIN  = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ADDR_W-1:0] page_base;
  logic [SB_W-1:0]   slot_bytes;
  logic [SIU_W-1:0]  slots_in_use;
  logic [GEN_W-1:0]  page_generation;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_base       <= '0;
      slot_bytes      <= SLOT_BYTES_RST;
      slots_in_use    <= SLOTS_IN_USE_RST;
      page_generation <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAGE_BASE:  page_base       <= cfg_data;
        REG_SLOT_BYTES: slot_bytes      <= cfg_data[SB_W-1:0];
        REG_SLOTS_USE:  slots_in_use    <= cfg_data[SIU_W-1:0];
        REG_PAGE_GEN:   page_generation <= cfg_data[GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched input transaction.
  logic [ADDR_W-1:0]   in_addr;
  logic [GEN_W-1:0]    in_gen;
  logic                in_any;
  logic [STRIPE_W-1:0] in_stripe;

  // Working registers.
  logic [ADDR_W-1:0] offset;
  logic [SP_W-1:0]   span;
  logic [IDX_W-1:0]  idx;
  logic [ST_W-1:0]   stripe_sel;
  logic [LK_W-1:0]   head;
  logic [ST_W:0]     sidx;
  logic [LK_W-1:0]   steps;
  logic [LK_W-1:0]   merged;

  // Alignment check on the offset; MIN_ALIGN is a power of two.
  logic aligned;
  assign aligned = ((offset & ADDR_W'(MIN_ALIGN - 1)) == '0);

  // Slot state.
  logic [SLOTS-1:0]  pending_map;
  logic [SLOTS-1:0]  local_mark_map;
  logic [LK_W-1:0]   stripe_top [STRIPES];
  logic [LK_W-1:0]   local_top;
  logic [LK_W-1:0]   local_free_total;
  logic [CNT_W-1:0]  invalid_counter;
  logic [CNT_W-1:0]  duplicate_counter;
  logic [CNT_W-1:0]  drain_event_counter;
  logic [CNT_W-1:0]  drained_slot_counter;
  logic [CNT_W-1:0]  drain_reject_counter;

  // Result waiting for the output register.
  status_t           res_status;
  logic [IDX_W-1:0]  res_slot;
  logic [LK_W-1:0]   res_merged;

  // Active slot count, clamped to the page capacity.
  logic [LK_W-1:0] active;
  always_comb begin
    if (32'(slots_in_use) > SLOTS) begin
      active = EMPTY;
    end else begin
      active = LK_W'(slots_in_use);
    end
  end

  // Stripe reduced modulo the stripe count (at most three subtractions).
  logic [STRIPE_W:0] st_red;
  always_comb begin
    st_red = (STRIPE_W + 1)'(in_stripe);
    for (int k = 0; k < 3; k++) begin
      if (32'(st_red) >= STRIPES) begin
        st_red = (STRIPE_W + 1)'(32'(st_red) - STRIPES);
      end
    end
  end

  // Divide unit for the slot index.
  div_ctrl_t        div_ctrl;
  logic [OFF_W-1:0] div_rem_init;
  logic [DV_W-1:0]  div_dv_init;
  logic             div_done;
  logic [OFF_W-1:0] div_rem;
  logic [IDX_W-1:0] div_quo;

  always_comb begin
    div_ctrl     = '0;
    div_rem_init = offset[OFF_W-1:0];
    div_dv_init  = DV_W'(slot_bytes) << (IDX_W - 1);
    if (state == S_CHK) begin
      div_ctrl.start = (offset < ADDR_W'(span)) && (in_any || in_gen == page_generation);
      div_ctrl.steps = STEP_W'(IDX_W);
    end
  end

  sprfe_div_unit #(
    .REM_W (OFF_W),
    .DV_W  (DV_W),
    .Q_W   (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .rem_init (div_rem_init),
    .dv_init  (div_dv_init),
    .done     (div_done),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // Link memory ports.
  logic             lk_we;
  logic [IDX_W-1:0] lk_waddr;
  logic [LK_W-1:0]  lk_wdata;
  logic [IDX_W-1:0] lk_raddr;
  logic [LK_W-1:0]  lk_rdata;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = head[IDX_W-1:0];
    lk_wdata = local_top;
    lk_raddr = head[IDX_W-1:0];
    if (state == S_MAP) begin
      lk_we    = !local_mark_map[idx] && !pending_map[idx];
      lk_waddr = idx;
      lk_wdata = stripe_top[stripe_sel];
    end else if (state == S_DRD) begin
      lk_we    = !local_mark_map[head[IDX_W-1:0]];
    end else if (state == S_TRD) begin
      lk_raddr = local_top[IDX_W-1:0];
    end
  end

  sprfe_link_ram #(
    .DEPTH (SLOTS),
    .AW    (IDX_W),
    .DW    (LK_W)
  ) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // Saturating counter helpers.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

  logic [CNT_W:0] drained_sum;
  assign drained_sum = (CNT_W + 1)'(drained_slot_counter) + (CNT_W + 1)'(merged);

  assign in_ch.ready = (state == S_IDLE);

  // Sequencer and slot state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      pending_map          <= '0;
      local_mark_map       <= '0;
      for (int s = 0; s < STRIPES; s++) begin
        stripe_top[s] <= EMPTY;
      end
      local_top            <= EMPTY;
      local_free_total     <= '0;
      invalid_counter      <= '0;
      duplicate_counter    <= '0;
      drain_event_counter  <= '0;
      drained_slot_counter <= '0;
      drain_reject_counter <= '0;
      out_ch.valid         <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_FIN) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            case (mode_t'(in_ch.mode))
              MODE_FREE:  state <= S_PREP;
              MODE_DRAIN: state <= S_DSEL;
              MODE_TAKE:  state <= S_TRD;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_PREP: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (div_ctrl.start) begin
            state <= S_DIV1;
          end else begin
            invalid_counter <= sat_inc(invalid_counter);
            state           <= S_FIN;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            if (div_rem == '0 && aligned) begin
              state <= S_MAP;
            end else begin
              invalid_counter <= sat_inc(invalid_counter);
              state           <= S_FIN;
            end
          end
        end
        S_MAP: begin
          if (local_mark_map[idx]) begin
            invalid_counter <= sat_inc(invalid_counter);
          end else if (pending_map[idx]) begin
            duplicate_counter <= sat_inc(duplicate_counter);
          end else begin
            pending_map[idx]       <= 1'b1;
            stripe_top[stripe_sel] <= LK_W'(idx);
          end
          state <= S_FIN;
        end
        S_DSEL: begin
          if (32'(sidx) >= STRIPES) begin
            if (merged != '0) begin
              drain_event_counter  <= sat_inc(drain_event_counter);
              drained_slot_counter <= drained_sum[CNT_W] ? '1 : drained_sum[CNT_W-1:0];
            end
            state <= S_FIN;
          end else begin
            stripe_top[sidx[ST_W-1:0]] <= EMPTY;
            state                      <= S_DCHK;
          end
        end
        S_DCHK: begin
          if (head == EMPTY || steps == EMPTY) begin
            state <= S_DSEL;
          end else begin
            state <= S_DRD;
          end
        end
        S_DRD: begin
          pending_map[head[IDX_W-1:0]] <= 1'b0;
          if (local_mark_map[head[IDX_W-1:0]]) begin
            drain_reject_counter <= sat_inc(drain_reject_counter);
            invalid_counter      <= sat_inc(invalid_counter);
          end else begin
            local_mark_map[head[IDX_W-1:0]] <= 1'b1;
            local_top                       <= head;
            local_free_total                <= local_free_total + LK_W'(1);
          end
          state <= S_DCHK;
        end
        S_TRD: begin
          state <= (local_top == EMPTY) ? S_FIN : S_TFIN;
        end
        S_TFIN: begin
          local_top                            <= lk_rdata;
          local_mark_map[local_top[IDX_W-1:0]] <= 1'b0;
          if (local_free_total != '0) begin
            local_free_total <= local_free_total - LK_W'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers and result fields; these need no reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        in_addr    <= in_ch.address;
        in_gen     <= in_ch.claimed_gen;
        in_any     <= in_ch.any_generation;
        in_stripe  <= in_ch.stripe;
        sidx       <= '0;
        steps      <= '0;
        merged     <= '0;
        res_status <= ST_INVALID;
        res_slot   <= '0;
        res_merged <= '0;
      end
      S_PREP: begin
        offset     <= in_addr - page_base;
        span       <= SP_W'(slot_bytes) * SP_W'(active);
        stripe_sel <= ST_W'(st_red);
      end
      S_DIV1: begin
        if (div_done) begin
          idx <= div_quo;
        end
      end
      S_MAP: begin
        if (local_mark_map[idx]) begin
          res_status <= ST_INVALID;
        end else if (pending_map[idx]) begin
          res_status <= ST_DUPLICATE;
        end else begin
          res_status <= ST_ACCEPTED;
          res_slot   <= idx;
        end
      end
      S_DSEL: begin
        res_status <= ST_DRAINED;
        res_merged <= merged;
        if (32'(sidx) < STRIPES) begin
          head <= stripe_top[sidx[ST_W-1:0]];
        end
      end
      S_DCHK: begin
        if (head == EMPTY || steps == EMPTY) begin
          sidx <= sidx + (ST_W + 1)'(1);
        end
      end
      S_DRD: begin
        head  <= lk_rdata;
        steps <= steps + LK_W'(1);
        if (!local_mark_map[head[IDX_W-1:0]]) begin
          merged <= merged + LK_W'(1);
        end
      end
      S_TRD: begin
        res_status <= (local_top == EMPTY) ? ST_EMPTY : ST_TAKEN;
        res_slot   <= local_top[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register, loaded as the transaction completes.
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_ch.valid || out_ch.ready)) begin
      out_ch.status          <= res_status;
      out_ch.slot_id         <= SLOTF_W'(res_slot);
      out_ch.merged_count    <= TOTF_W'(res_merged);
      out_ch.free_slots      <= TOTF_W'(local_free_total);
      out_ch.invalid_total   <= invalid_counter;
      out_ch.duplicate_total <= duplicate_counter;
    end
  end
endmodule
`default_nettype wire

// ===== src/sprfe_div_unit.sv =====
// Restoring divide unit: one compare and subtract per cycle.
// Depends on sprfe_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none
module sprfe_div_unit #(
  parameter int REM_W = 25,
  parameter int DV_W  = 30,
  parameter int Q_W   = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  sprfe_pkg::div_ctrl_t         ctrl,
  input  wire  [REM_W-1:0]             rem_init,
  input  wire  [DV_W-1:0]              dv_init,
  output logic                         done,
  output logic [REM_W-1:0]             rem,
  output logic [Q_W-1:0]               quo
);
  import sprfe_pkg::*;

  logic [DV_W-1:0]   dv;
  logic [STEP_W-1:0] cnt;
  logic              running;
  logic [DV_W-1:0]   rem_ext;
  logic              ge;

  // One quotient bit: compare the remainder with the shifted divisor.
  assign rem_ext = DV_W'(rem);
  assign ge      = (rem_ext >= dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (ctrl.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= ctrl.steps;
    end else if (running) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= rem_init;
      dv  <= dv_init;
      quo <= '0;
    end else if (running) begin
      if (ge) begin
        rem <= REM_W'(rem_ext - dv);
      end
      quo <= {quo[Q_W-2:0], ge};
      dv  <= dv >> 1;
    end
  end
endmodule
`default_nettype wire

// ===== src/sprfe_link_ram.sv =====
// Link memory of the slot stacks: one write port, one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module sprfe_link_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [DW-1:0] wdata,
  input  wire  [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
